// ----- hw/rtl/nsci_pkg.sv -----
`default_nettype none
package nsci_pkg;
    localparam int unsigned MaxArgs = 64;
    localparam int unsigned SetW = 64;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 7;
    localparam logic [CfgIdxW-1:0] CfgArgCount = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgPrune = 1'd1;
    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_CLOSURE = 2'd1,
        REQ_NEXT = 2'd2,
        REQ_NONE = 2'd3
    } t_req;
    // tdata widths of the input and output streams
    localparam int unsigned InDataW = 136;
    localparam int unsigned OutDataW = 72;
endpackage
`default_nettype wire

// ----- hw/rtl/nsci_mat.sv -----
`default_nettype none
// row memory with one registered read port and one write port
module nsci_mat #(
    parameter int unsigned Depth = 64,
    parameter int unsigned Width = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/next_semi_complete_intent_top.sv -----
`default_nettype none
// a load writes its row and returns to idle; a query first rebuilds the tables when rows or the count changed
// (a clear pass over all MAX_ARGUMENTS rows, then the transpose and defended-set passes),
// then a victim pass and closure passes until no argument is added, and
// for next queries one closure per tried candidate, then a self-defense check; input is taken
// one beat at a time; a finished result waits in the output register while the next runs
// synchronous active-low reset clears control and row valid bits and marks tables stale
module next_semi_complete_intent_top #(
    parameter int unsigned MAX_ARGUMENTS = nsci_pkg::MaxArgs
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [nsci_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [nsci_pkg::CfgDataW-1:0] i_cfg_data,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // req_type[1:0], row_index[7:2], row_bits[71:8], set_bits[135:72]
    input  wire logic [nsci_pkg::InDataW-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // result_set[63:0], found[64], self_defending[65], zero pad above
    output logic [nsci_pkg::OutDataW-1:0]     m_axis_tdata
);
    import nsci_pkg::*;
    localparam int unsigned N = MAX_ARGUMENTS;
    localparam int unsigned AW = $clog2(N);
    localparam int unsigned CW = $clog2(N + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_CLR, S_TR_RD, S_TR_WR, S_DS_RDI, S_DS_RDJ, S_DS_CHK,
        S_CL_INIT, S_CL_RD, S_CL_STEP, S_NX_SCAN, S_NX_RDI, S_NX_CHK,
        S_NX_CL_DONE, S_NX_GD_RD, S_NX_GD_CHK, S_SD_RD, S_SD_ACC, S_OUT
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_n;
    logic r_prune, r_stale, r_is_next;
    logic [SetW-1:0] r_set, r_tmp, r_comp, r_res, r_v, r_att, r_peace, r_rowi, r_mask;
    logic [AW-1:0] r_i, r_j;
    logic r_changed, r_found, r_sd;
    logic [SetW-1:0] r_out_set;
    logic r_out_found, r_out_sd, r_ovalid;
    logic [1:0] r_ph; // low bit 0 next scan closure, 1 plain closure; high bit marks the defended passes
    logic [N-1:0] r_aval;
    logic r_arok;

    // memories
    logic a_we, t_we, d_we;
    logic [AW-1:0] a_wa, a_ra, t_wa, t_ra, d_wa, d_ra;
    logic [SetW-1:0] a_wd, a_rd, t_wd, t_rd, d_wd, d_rd;

    nsci_mat #(.Depth(N), .Width(SetW)) u_atk (.i_clk, .i_we(a_we), .i_waddr(a_wa),
        .i_wdata(a_wd), .i_raddr(a_ra), .o_rdata(a_rd));
    nsci_mat #(.Depth(N), .Width(SetW)) u_atr (.i_clk, .i_we(t_we), .i_waddr(t_wa),
        .i_wdata(t_wd), .i_raddr(t_ra), .o_rdata(t_rd));
    nsci_mat #(.Depth(N), .Width(SetW)) u_dsm (.i_clk, .i_we(d_we), .i_waddr(d_wa),
        .i_wdata(d_wd), .i_raddr(d_ra), .o_rdata(d_rd));

    logic [1:0] w_req;
    logic [5:0] w_idx;
    logic [SetW-1:0] w_row, w_qset;
    assign w_req = s_axis_tdata[1:0];
    assign w_idx = s_axis_tdata[7:2];
    assign w_row = s_axis_tdata[71:8];
    assign w_qset = s_axis_tdata[135:72];

    logic [SetW-1:0] w_arow, w_bit_i, w_bit_j;
    assign w_arow = (r_arok ? a_rd : '0) & r_mask;
    assign w_bit_i = SetW'(1) << r_i;
    assign w_bit_j = SetW'(1) << r_j;
    logic w_i_last, w_j_last;
    assign w_i_last = (CW'(r_i) == r_n - CW'(1));
    assign w_j_last = (CW'(r_j) == r_n - CW'(1));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {6'd0, r_out_sd, r_out_found, r_out_set};

    // write ports: attack rows on load; table clear; transpose bits by rmw of t_rd; defended-set rows
    always_comb begin
        a_we = (r_state == S_IDLE) && s_axis_tvalid && s_axis_tready
               && (w_req == REQ_LOAD) && (int'(w_idx) < N);
        a_wa = AW'(w_idx);
        a_wd = w_row;
        a_ra = r_i;
        t_we = 1'b0; t_wa = r_j; t_wd = t_rd | w_bit_i; t_ra = r_j;
        d_we = 1'b0; d_wa = r_i; d_wd = '0; d_ra = r_i;
        unique case (r_state)
            S_CLR: begin
                t_we = 1'b1; t_wa = r_i; t_wd = '0;
                d_we = 1'b1; d_wa = r_i; d_wd = '0;
            end
            S_TR_WR: t_we = w_arow[r_j];
            S_DS_RDI, S_DS_RDJ: t_ra = r_j;
            S_DS_CHK: begin
                d_we = 1'b1; d_wa = r_i;
                d_wd = r_att | (((t_rd & ~r_rowi) == '0 && r_j < r_i) ? w_bit_j : '0);
            end
            S_CL_RD, S_NX_RDI, S_SD_RD, S_NX_GD_RD: t_ra = r_i;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n <= CW'(N);
            r_prune <= 1'b1;
            r_stale <= 1'b1;
            r_ovalid <= 1'b0;
            r_aval <= '0;
        end else begin
            r_arok <= r_aval[a_ra];
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CfgArgCount) begin
                    r_stale <= 1'b1;
                    if (i_cfg_data == '0) r_n <= CW'(1);
                    else if (32'(i_cfg_data) > N) r_n <= CW'(N);
                    else r_n <= CW'(i_cfg_data);
                end else if (i_cfg_index == CfgPrune) begin
                    r_prune <= i_cfg_data[0];
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    r_mask <= (32'(r_n) >= SetW) ? '1 : ((SetW'(1) << r_n) - SetW'(1));
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_set <= w_qset;
                        r_is_next <= (w_req == REQ_NEXT);
                        if (w_req == REQ_LOAD) begin
                            if (int'(w_idx) < N) begin
                                r_stale <= 1'b1;
                                r_aval[AW'(w_idx)] <= 1'b1;
                            end
                            r_state <= S_LOAD;
                        end else if (w_req != REQ_NONE) begin
                            r_i <= '0;
                            r_state <= r_stale ? S_CLR : S_CL_INIT;
                        end
                    end
                end
                S_LOAD: r_state <= S_IDLE;
                S_CLR: begin
                    r_peace <= '0;
                    r_i <= r_i + AW'(1);
                    if (32'(r_i) == N - 1) begin
                        r_i <= '0; r_j <= '0; r_state <= S_TR_RD;
                    end
                end
                // transpose: for each (i,j) set attacker bit i of row j
                S_TR_RD: r_state <= S_TR_WR;
                S_TR_WR: begin
                    if (r_j == '0 && w_arow == '0) r_peace <= r_peace | w_bit_i;
                    r_state <= S_TR_RD;
                    if (w_j_last) begin
                        r_j <= '0;
                        if (w_i_last) begin r_i <= '0; r_state <= S_DS_RDI; end
                        else r_i <= r_i + AW'(1);
                    end else r_j <= r_j + AW'(1);
                end
                S_DS_RDI: begin r_j <= '0; r_att <= '0; r_state <= S_DS_RDJ; end
                S_DS_RDJ: begin r_rowi <= w_arow; r_state <= S_DS_CHK; end
                S_DS_CHK: begin
                    r_att <= d_wd;
                    r_state <= S_DS_RDJ;
                    if (r_j >= r_i || w_j_last) begin
                        if (w_i_last) begin
                            r_stale <= 1'b0; r_i <= '0; r_state <= S_CL_INIT;
                        end else begin
                            r_i <= r_i + AW'(1); r_state <= S_DS_RDI;
                        end
                    end else r_j <= r_j + AW'(1);
                end
                S_CL_INIT: begin
                    r_comp <= ~r_set & r_mask;
                    r_tmp <= r_set & r_mask;
                    r_found <= 1'b1;
                    if (r_is_next) begin
                        r_i <= AW'(r_n - CW'(1)); r_state <= S_NX_SCAN;
                    end else begin
                        r_res <= r_set & r_mask; r_ph <= 2'd1;
                        r_i <= '0; r_v <= '0; r_state <= S_CL_RD;
                    end
                end
                // closure: first pass builds victims, later passes add defended
                S_CL_RD: r_state <= S_CL_STEP;
                S_CL_STEP: begin
                    if (r_ph[1] == 1'b0) begin
                        if (r_res[r_i]) r_v <= r_v | w_arow;
                    end else if (!r_res[r_i] && (t_rd & ~r_v) == '0) begin
                        r_res <= r_res | w_bit_i;
                        r_v <= r_v | w_arow;
                        r_changed <= 1'b1;
                    end
                    r_state <= S_CL_RD;
                    if (w_i_last) begin
                        r_i <= '0;
                        if (r_ph[1] == 1'b0) begin
                            r_ph[1] <= 1'b1; r_changed <= 1'b0;
                        end else if (!(r_changed || (!r_res[r_i]
                                    && (t_rd & ~r_v) == '0))) begin
                            r_ph[1] <= 1'b0;
                            r_state <= r_ph[0] ? S_SD_RD : S_NX_CL_DONE;
                            r_att <= '0;
                        end else r_changed <= 1'b0;
                    end else r_i <= r_i + AW'(1);
                end
                S_NX_SCAN: begin
                    if (r_tmp[r_i]) begin
                        r_tmp <= r_tmp & ~w_bit_i;
                        if (r_i == '0) begin
                            r_found <= 1'b0; r_res <= '0; r_state <= S_OUT;
                            r_sd <= 1'b0;
                        end else r_i <= r_i - AW'(1);
                    end else if (r_prune && r_peace[r_i]) begin
                        if (r_i == '0) begin
                            r_found <= 1'b0; r_res <= '0; r_state <= S_OUT;
                            r_sd <= 1'b0;
                        end else r_i <= r_i - AW'(1);
                    end else r_state <= S_NX_RDI;
                end
                S_NX_RDI: r_state <= S_NX_CHK;
                S_NX_CHK: begin
                    if (w_arow[r_i] || (w_arow & r_tmp) != '0
                        || (r_prune && (r_comp & d_rd) != '0)
                        || (t_rd & r_tmp) != '0) begin
                        if (r_i == '0) begin
                            r_found <= 1'b0; r_res <= '0; r_state <= S_OUT;
                            r_sd <= 1'b0;
                        end else begin
                            r_i <= r_i - AW'(1); r_state <= S_NX_SCAN;
                        end
                    end else begin
                        r_tmp <= r_tmp | w_bit_i;
                        r_res <= r_tmp | w_bit_i;
                        r_j <= r_i;
                        r_i <= '0; r_v <= '0; r_ph <= 2'd0;
                        r_state <= S_CL_RD;
                    end
                end
                S_NX_CL_DONE: begin
                    // r_j holds the candidate, restore it as scan index
                    r_i <= r_j;
                    if ((r_res & ~r_tmp & ((SetW'(1) << r_j) - SetW'(1))) != '0) begin
                        r_tmp <= r_tmp & ~(SetW'(1) << r_j);
                        if (r_j == '0) begin
                            r_found <= 1'b0; r_res <= '0; r_sd <= 1'b0; r_state <= S_OUT;
                        end else begin
                            r_i <= r_j - AW'(1); r_state <= S_NX_SCAN;
                        end
                    end else if (w_j_last) begin
                        r_i <= '0; r_att <= '0; r_state <= S_SD_RD;
                    end else begin
                        r_i <= r_j + AW'(1); r_state <= S_NX_GD_RD;
                    end
                end
                S_NX_GD_RD: r_state <= S_NX_GD_CHK;
                S_NX_GD_CHK: begin
                    if (r_res[r_i] && (w_arow & r_res) != '0 && (t_rd & r_tmp) != '0) begin
                        r_tmp <= r_tmp & ~w_bit_j;
                        if (r_j == '0) begin
                            r_found <= 1'b0; r_res <= '0; r_sd <= 1'b0; r_state <= S_OUT;
                        end else begin
                            r_i <= r_j - AW'(1); r_state <= S_NX_SCAN;
                        end
                    end else if (w_i_last) begin
                        r_i <= '0; r_att <= '0; r_state <= S_SD_RD;
                    end else begin
                        r_i <= r_i + AW'(1); r_state <= S_NX_GD_RD;
                    end
                end
                // self defense: attackers union and victims union over result
                S_SD_RD: begin
                    if (r_i == '0) r_v <= '0;
                    r_state <= S_SD_ACC;
                end
                S_SD_ACC: begin
                    if (r_res[r_i]) begin
                        r_att <= r_att | t_rd; r_v <= r_v | w_arow;
                    end
                    if (w_i_last) begin
                        r_sd <= ((r_att | (r_res[r_i] ? t_rd : '0))
                                 & ~(r_v | (r_res[r_i] ? w_arow : '0))) == '0;
                        r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + AW'(1); r_state <= S_SD_RD;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_out_set <= r_res;
                        r_out_found <= r_found;
                        r_out_sd <= r_found && r_sd;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_ovalid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("result beat not raised");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CL_INIT) |-> !r_stale)
        else $error("query on stale tables");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[65]) |-> m_axis_tdata[64])
        else $error("self defending without found");
endmodule
`default_nettype wire

// ----- test/next_semi_complete_intent_top_test.sv -----
module next_semi_complete_intent_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import nsci_pkg::*;

    localparam int unsigned IdleLimit = 5000000;
    localparam int unsigned SettleCycles = 300;

    typedef struct packed {
        logic [63:0] set;
        logic        found;
        logic        selfdef;
    } t_intent;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CfgIdxW-1:0]   i_cfg_index;
    logic [CfgDataW-1:0]  i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OutDataW-1:0]  m_axis_tdata;

    next_semi_complete_intent_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // graph mirror
    logic [63:0] attacks [MaxArgs];
    logic [63:0] attackers_of [MaxArgs];
    logic [63:0] defends_lower [MaxArgs];
    logic [63:0] peaceful;
    logic        graph_stale;
    logic [6:0]  arg_count;
    logic        prune_on;

    t_intent     intent_q [$];
    int unsigned errors;
    int unsigned beats_sent;
    int unsigned intents_seen;
    int unsigned burst_left;
    int unsigned hold_req;
    int unsigned hold_left;
    int unsigned stall_style;
    int unsigned stall_phase;
    int unsigned idle_cycles;
    t_intent     last_intent;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] low_bits(input int k);
        return (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
    endfunction

    function automatic int live_count();
        if (arg_count == 0) return 1;
        if (arg_count > MaxArgs) return int'(MaxArgs);
        return int'(arg_count);
    endfunction

    function automatic logic [63:0] row_at(input int i, input int n);
        return attacks[i] & low_bits(n);
    endfunction

    function automatic void rebuild_graph(input int n);
        logic [63:0] row;
        peaceful = '0;
        for (int j = 0; j < MaxArgs; j++) begin
            attackers_of[j] = '0;
            defends_lower[j] = '0;
        end
        for (int i = 0; i < n; i++) begin
            row = row_at(i, n);
            if (row == 0) peaceful[i] = 1'b1;
            for (int j = 0; j < n; j++)
                if (row[j]) attackers_of[j][i] = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            row = row_at(i, n);
            for (int j = 0; j < i; j++)
                if ((attackers_of[j] & ~row) == 0) defends_lower[i][j] = 1'b1;
        end
        graph_stale = 1'b0;
    endfunction

    function automatic logic [63:0] victims(input logic [63:0] s, input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            if (s[i]) v |= row_at(i, n);
        return v;
    endfunction

    function automatic logic [63:0] closure(input logic [63:0] s, input int n);
        logic [63:0] r;
        logic [63:0] v;
        logic        grew;
        r = s;
        v = victims(r, n);
        do begin
            grew = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!r[i] && (attackers_of[i] & ~v) == 0) begin
                    r[i] = 1'b1;
                    v |= row_at(i, n);
                    grew = 1'b1;
                end
            end
        end while (grew);
        return r;
    endfunction

    function automatic logic self_defending(input logic [63:0] s, input int n);
        logic [63:0] att;
        att = '0;
        for (int i = 0; i < n; i++)
            if (s[i]) att |= attackers_of[i];
        return (att & ~victims(s, n)) == 0;
    endfunction

    function automatic logic next_intent(input logic [63:0] cur, input int n,
                                         output logic [63:0] res);
        logic [63:0] tmp;
        logic [63:0] comp;
        logic [63:0] row;
        logic [63:0] nx;
        logic        good;
        tmp = cur & low_bits(n);
        comp = ~tmp & low_bits(n);
        res = '0;
        for (int u = n - 1; u >= 0; u--) begin
            row = row_at(u, n);
            if (tmp[u]) begin
                tmp[u] = 1'b0;
                continue;
            end
            if (prune_on && peaceful[u]) continue;
            if (row[u]) continue;
            if ((row & tmp) != 0) continue;
            if (prune_on && (comp & defends_lower[u]) != 0) continue;
            if ((attackers_of[u] & tmp) != 0) continue;
            tmp[u] = 1'b1;
            nx = closure(tmp, n);
            good = (nx & ~tmp & low_bits(u)) == 0;
            for (int j = u + 1; good && j < n; j++)
                if (nx[j] && (row_at(j, n) & nx) != 0 && (attackers_of[j] & tmp) != 0)
                    good = 1'b0;
            if (good) begin
                res = nx;
                return 1'b1;
            end
            tmp[u] = 1'b0;
        end
        return 1'b0;
    endfunction

    // updates the mirror for one accepted beat, queues the answer if any
    function automatic void predict_beat(input t_req req, input logic [5:0] idx,
                                         input logic [63:0] row, input logic [63:0] set);
        int      n;
        t_intent e;
        n = live_count();
        if (req == REQ_LOAD) begin
            attacks[idx] = row;
            graph_stale = 1'b1;
            return;
        end
        if (req == REQ_NONE) return;
        if (graph_stale) rebuild_graph(n);
        if (req == REQ_CLOSURE) begin
            e.set = closure(set & low_bits(n), n);
            e.found = 1'b1;
        end else begin
            e.found = next_intent(set, n, e.set);
        end
        e.selfdef = e.found && self_defending(e.set, n);
        intent_q.push_back(e);
        last_intent = e;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] sparse64();
        return rand64() & rand64() & rand64();
    endfunction

    task automatic send_beat(input t_req req, input logic [5:0] idx,
                             input logic [63:0] row, input logic [63:0] set);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tdata <= {set, row, idx, req};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
        predict_beat(req, idx, row, set);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain();
        stop_sending();
        while (intent_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [6:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgArgCount) begin
            arg_count = val;
            graph_stale = 1'b1;
        end else begin
            prune_on = val[0];
        end
    endtask

    // walks the enumeration from a start set, mixing in closures
    task automatic walk_intents(input logic [63:0] start, input int steps);
        logic [63:0] cur;
        cur = start;
        for (int k = 0; k < steps; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_beat(REQ_CLOSURE, '0, rand64(), rand64());
            end else begin
                send_beat(REQ_NEXT, 6'($urandom()), rand64(), cur);
                cur = last_intent.found ? last_intent.set : '0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("error: %s got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    always @(posedge i_clk) begin
        t_intent e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            intents_seen++;
            if (intent_q.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
            end else begin
                e = intent_q.pop_front();
                if (m_axis_tdata[63:0] !== e.set)
                    report_mismatch("result_set", m_axis_tdata[63:0], e.set);
                if (m_axis_tdata[64] !== e.found)
                    report_mismatch("found", 64'(m_axis_tdata[64]), 64'(e.found));
                if (m_axis_tdata[65] !== e.selfdef)
                    report_mismatch("self_defending", 64'(m_axis_tdata[65]),
                                    64'(e.selfdef));
            end
        end
    end

    // receiver stall pattern plus long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (stall_phase == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_phase = $urandom_range(20, 80);
        end
        stall_phase--;
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (stall_phase % 8) < 5;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IdleLimit) begin
            $display("next_semi_complete_intent_top: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        send_beat(REQ_LOAD, 6'd0, '1, '0);
        send_beat(REQ_LOAD, 6'd63, 64'h1, '1);
        send_beat(REQ_LOAD, 6'd5, '0, '0);
        send_beat(REQ_LOAD, 6'd7, 64'h8000_0000_0000_0100, '0);
        send_beat(REQ_CLOSURE, '0, '0, '0);
        send_beat(REQ_CLOSURE, '0, '0, '1);
        send_beat(REQ_NEXT, '0, '0, '0);
        send_beat(REQ_NEXT, '0, '0, '1);
        send_beat(REQ_NONE, 6'd3, '1, '1);
        send_beat(REQ_CLOSURE, '0, '0, 64'h5555_5555_5555_5555);
        write_reg(CfgPrune, 7'd0);
        send_beat(REQ_NEXT, '0, '0, '0);
        send_beat(REQ_NEXT, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA);
        write_reg(CfgArgCount, 7'd0);
        send_beat(REQ_NEXT, '0, '0, '0);
        send_beat(REQ_CLOSURE, '0, '0, '1);
        send_beat(REQ_NEXT, '0, '0, '1);
        write_reg(CfgArgCount, 7'd127);
        write_reg(CfgPrune, 7'd1);
        send_beat(REQ_LOAD, 6'd0, '0, '0);
        send_beat(REQ_CLOSURE, '0, '0, '0);
        send_beat(REQ_NEXT, '0, '0, '0);
        write_reg(CfgArgCount, 7'd65);
        send_beat(REQ_NEXT, '0, '0, 64'h8000_0000_0000_0001);
    endtask

    task automatic test_count_sweep();
        int sizes [3] = '{2, 5, 9};
        foreach (sizes[s]) begin
            for (int p = 0; p < 2; p++) begin
                write_reg(CfgArgCount, 7'(sizes[s]));
                write_reg(CfgPrune, 7'(p));
                for (int r = 0; r < sizes[s]; r++)
                    send_beat(REQ_LOAD, 6'(r),
                              ($urandom_range(0, 3) == 0) ? rand64() : sparse64(), rand64());
                walk_intents('0, 4);
            end
        end
    endtask

    task automatic test_full_graph();
        write_reg(CfgArgCount, 7'd64);
        write_reg(CfgPrune, 7'($urandom_range(0, 1)));
        for (int r = 0; r < 24; r++)
            send_beat(REQ_LOAD, 6'($urandom_range(0, 63)), sparse64() & sparse64(), '0);
        walk_intents('0, 6);
        send_beat(REQ_LOAD, 6'($urandom_range(0, 63)), rand64(), rand64());
        send_beat(REQ_CLOSURE, '0, '0, rand64());
        send_beat(REQ_NEXT, '0, '0, rand64());
    endtask

    task automatic test_random_mix();
        int k;
        write_reg(CfgArgCount, 7'($urandom_range(4, 10)));
        write_reg(CfgPrune, 7'd1);
        for (int r = 0; r < 6; r++)
            send_beat(REQ_LOAD, 6'(r), sparse64(), rand64());
        for (k = 0; k < 8; k++) begin
            case ($urandom_range(0, 9))
                0: send_beat(REQ_LOAD, 6'($urandom_range(0, 63)), sparse64(), rand64());
                1: send_beat(REQ_NONE, 6'($urandom()), rand64(), rand64());
                2, 3: send_beat(REQ_CLOSURE, 6'($urandom()), rand64(), rand64());
                default: walk_intents(($urandom_range(0, 2) == 0) ? rand64() : '0, 3);
            endcase
        end
    endtask

    task automatic test_backpressure();
        write_reg(CfgArgCount, 7'd8);
        hold_req = 2000;
        for (int k = 0; k < 12; k++)
            send_beat(($urandom_range(0, 1) == 0) ? REQ_CLOSURE : REQ_NEXT, '0, '0, rand64());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        beats_sent = 0;
        intents_seen = 0;
        burst_left = 0;
        hold_req = 0;
        hold_left = 0;
        stall_phase = 0;
        stall_style = 0;
        idle_cycles = 0;
        for (int i = 0; i < MaxArgs; i++) begin
            attacks[i] = '0;
            attackers_of[i] = '0;
            defends_lower[i] = '0;
        end
        peaceful = '0;
        graph_stale = 1'b1;
        arg_count = 7'd64;
        prune_on = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_count_sweep();
        test_full_graph();
        test_random_mix();
        test_backpressure();
        drain();

        $display("covered %0d input beats and %0d results over counts 1..64,",
                 beats_sent, intents_seen);
        $display("both pruning modes, loads, ignored requests and a long output hold-off");
        if (errors == 0 && intent_q.size() == 0) begin
            $display("next_semi_complete_intent_top: match");
        end else begin
            $display("next_semi_complete_intent_top: mismatch");
        end
        $finish;
    end
endmodule
